FILE: design/ccti_pkg.sv
// Shared widths and constants for the cycle count time interpolator.
`timescale 1ns / 1ps

package ccti_pkg;

    localparam int SEC_W     = 32;
    localparam int USEC_W    = 20;
    localparam int CYC_W     = 32;
    localparam int PROD_W    = CYC_W + USEC_W;
    localparam int S_DATA_W  = 120;
    localparam int M_DATA_W  = 56;
    localparam int M_USER_W  = 2;

    localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);
    localparam logic [USEC_W-1:0] USEC_MAX     = USEC_W'(999999);
    localparam logic [CYC_W-1:0]  RATE_RESET   = CYC_W'(100000000);

endpackage

FILE: design/ccti_mul.sv
// Bit-serial multiply of the elapsed cycle count by one million, MSB first.
`timescale 1ns / 1ps

module ccti_mul
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ccti_pkg::CYC_W-1:0]   multiplicand,
    output logic [ccti_pkg::PROD_W-1:0]  product,
    output logic                         done
);

    localparam int CntW = $clog2(ccti_pkg::CYC_W);

    logic [ccti_pkg::CYC_W-1:0]  shift_reg;
    logic [ccti_pkg::PROD_W-1:0] acc_reg;
    logic [ccti_pkg::PROD_W-1:0] acc_next;
    logic [CntW-1:0]             cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    // acc = 2*acc + bit * 1e6
    always_comb
    begin
        acc_next = {acc_reg[ccti_pkg::PROD_W-2:0], 1'b0}
                 + (shift_reg[ccti_pkg::CYC_W-1]
                    ? ccti_pkg::PROD_W'(ccti_pkg::USEC_PER_SEC)
                    : ccti_pkg::PROD_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // one-cycle pulse after the last step
            done_reg <= busy_reg && !start && (cnt_reg == '0);
            if (start)
            begin
                shift_reg <= multiplicand;
                acc_reg   <= '0;
                cnt_reg   <= CntW'(ccti_pkg::CYC_W - 1);
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg   <= acc_next;
                shift_reg <= {shift_reg[ccti_pkg::CYC_W-2:0], 1'b0};
                cnt_reg   <= cnt_reg - CntW'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

FILE: design/ccti_div.sv
// Restoring bit-serial divide; quotient assumed below 2^20 (high dividend part < divisor).
`timescale 1ns / 1ps

module ccti_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ccti_pkg::PROD_W-1:0]  dividend,
    input  logic [ccti_pkg::CYC_W-1:0]   divisor,
    output logic [ccti_pkg::USEC_W-1:0]  quotient,
    output logic                         done
);

    localparam int CntW = $clog2(ccti_pkg::USEC_W);

    logic [ccti_pkg::CYC_W-1:0]  rem_reg;
    logic [ccti_pkg::USEC_W-1:0] low_reg;
    logic [ccti_pkg::USEC_W-1:0] q_reg;
    logic [CntW-1:0]             cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [ccti_pkg::CYC_W:0]    trial;
    logic [ccti_pkg::CYC_W+1:0]  diff;

    always_comb
    begin
        trial = {rem_reg, low_reg[ccti_pkg::USEC_W-1]};
        diff  = {1'b0, trial} - {2'b00, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            low_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            // one-cycle pulse after the last step
            done_reg <= busy_reg && !start && (cnt_reg == '0);
            if (start)
            begin
                rem_reg  <= dividend[ccti_pkg::PROD_W-1:ccti_pkg::USEC_W];
                low_reg  <= dividend[ccti_pkg::USEC_W-1:0];
                q_reg    <= '0;
                cnt_reg  <= CntW'(ccti_pkg::USEC_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // borrow clear: divisor fits, keep the difference
                if (!diff[ccti_pkg::CYC_W+1])
                begin
                    rem_reg <= diff[ccti_pkg::CYC_W-1:0];
                end
                else
                begin
                    rem_reg <= trial[ccti_pkg::CYC_W-1:0];
                end
                q_reg   <= {q_reg[ccti_pkg::USEC_W-2:0], ~diff[ccti_pkg::CYC_W+1]};
                low_reg <= {low_reg[ccti_pkg::USEC_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - CntW'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

FILE: design/cycle_count_time_interpolator_core.sv
// Top level of the cycle count time interpolator: control, time adjust and output word.
`timescale 1ns / 1ps

// Turns a published time snapshot plus a cycle counter reading into a
// (seconds, microseconds) time. Elapsed cycles are current minus
// snapshot count modulo 2^32 (one counter wrap allowed), scaled to microseconds
// as floor(elapsed * 1000000 / cycles_per_second). An elapsed time of a second
// or more clips to 999999 us and sets offset_saturated. A result in the same
// second as the last one given and not ahead of it becomes last + 1 us and sets
// bumped. Snapshot microseconds above 999999 are clamped; a rate of 0 acts as 1.
// One word is in flight at a time: the time from one input accept to the next
// is set by the 32-step bit-serial multiply by one million and the 20-step
// restoring divide by the clock rate; it is longer only if the previous
// result is still unread when this one is ready. The result sits in an
// output register, so the next input word is taken while it waits for
// m_axis_tready.
// cfg_wdata is written on cfg_we; write it only while no word is in flight.

module cycle_count_time_interpolator_core
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [ccti_pkg::CYC_W-1:0]      cfg_wdata,     // cycles_per_second

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] snapshot_seconds, [51:32] snapshot_micros,
    // [83:52] snapshot_cycles, [115:84] current_cycles, [119:116] zero
    input  logic [ccti_pkg::S_DATA_W-1:0]   s_axis_tdata,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] time_seconds, [51:32] time_micros, [55:52] zero
    output logic [ccti_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // [0] offset_saturated, [1] bumped
    output logic [ccti_pkg::M_USER_W-1:0]   m_axis_tuser
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_DIV,
        ST_ADD,
        ST_MONO
    } state_t;

    state_t                          state_reg;
    logic [ccti_pkg::CYC_W-1:0]      rate_cfg_reg;
    logic [ccti_pkg::CYC_W-1:0]      elapsed_reg;
    logic [ccti_pkg::SEC_W-1:0]      sec_reg;
    logic [ccti_pkg::USEC_W-1:0]     usec_reg;
    logic                            sat_reg;
    logic [ccti_pkg::SEC_W-1:0]      last_sec_reg;
    logic [ccti_pkg::USEC_W-1:0]     last_usec_reg;
    logic                            m_valid_reg;
    logic [ccti_pkg::M_DATA_W-1:0]   m_data_reg;
    logic [ccti_pkg::M_USER_W-1:0]   m_user_reg;

    logic [ccti_pkg::CYC_W-1:0]      rate;
    logic [ccti_pkg::SEC_W-1:0]      in_sec;
    logic [ccti_pkg::USEC_W-1:0]     in_usec;
    logic [ccti_pkg::CYC_W-1:0]      in_snap_cyc;
    logic [ccti_pkg::CYC_W-1:0]      in_cur_cyc;
    logic [ccti_pkg::USEC_W-1:0]     usec_clamped;
    logic                            in_fire;

    logic                            mul_start;
    logic                            mul_done;
    logic [ccti_pkg::PROD_W-1:0]     product;
    logic                            div_start;
    logic                            div_done;
    logic [ccti_pkg::USEC_W-1:0]     quotient;

    logic [ccti_pkg::USEC_W:0]       usec_sum;
    logic                            add_carry;
    logic [ccti_pkg::USEC_W-1:0]     usec_add_next;
    logic [ccti_pkg::SEC_W-1:0]      sec_add_next;

    logic                            bump_hit;
    logic [ccti_pkg::USEC_W:0]       last_inc;
    logic                            bump_carry;
    logic [ccti_pkg::USEC_W-1:0]     usec_out_next;
    logic [ccti_pkg::SEC_W-1:0]      sec_out_next;
    logic                            out_load;

    // input word fields
    assign in_sec      = s_axis_tdata[31:0];
    assign in_usec     = s_axis_tdata[51:32];
    assign in_snap_cyc = s_axis_tdata[83:52];
    assign in_cur_cyc  = s_axis_tdata[115:84];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign usec_clamped = (in_usec > ccti_pkg::USEC_MAX) ? ccti_pkg::USEC_MAX : in_usec;

    // zero rate acts as one
    assign rate = (rate_cfg_reg == '0) ? ccti_pkg::CYC_W'(1) : rate_cfg_reg;

    assign mul_start = (state_reg == ST_START);
    assign div_start = (state_reg == ST_MUL) && mul_done;

    ccti_mul u_mul
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (elapsed_reg),
        .product      (product),
        .done         (mul_done)
    );

    // Divide only needs a valid answer when elapsed < rate, which keeps the
    // quotient below one million; otherwise the clipped value is used.
    ccti_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (rate),
        .quotient (quotient),
        .done     (div_done)
    );

    // snapshot micros + offset, carry into seconds
    always_comb
    begin
        usec_sum  = {1'b0, usec_reg}
                  + {1'b0, (sat_reg ? ccti_pkg::USEC_MAX : quotient)};
        add_carry = (usec_sum >= {1'b0, ccti_pkg::USEC_PER_SEC});
        if (add_carry)
        begin
            usec_add_next = ccti_pkg::USEC_W'(usec_sum - {1'b0, ccti_pkg::USEC_PER_SEC});
        end
        else
        begin
            usec_add_next = usec_sum[ccti_pkg::USEC_W-1:0];
        end
        sec_add_next = sec_reg + ccti_pkg::SEC_W'(add_carry);
    end

    // monotonic bump against the last time given; earlier seconds pass as is
    always_comb
    begin
        bump_hit   = (sec_reg == last_sec_reg) && (usec_reg <= last_usec_reg);
        last_inc   = {1'b0, last_usec_reg} + (ccti_pkg::USEC_W + 1)'(1);
        bump_carry = (last_inc >= {1'b0, ccti_pkg::USEC_PER_SEC});
        if (!bump_hit)
        begin
            usec_out_next = usec_reg;
            sec_out_next  = sec_reg;
        end
        else if (bump_carry)
        begin
            usec_out_next = ccti_pkg::USEC_W'(last_inc - {1'b0, ccti_pkg::USEC_PER_SEC});
            sec_out_next  = last_sec_reg + ccti_pkg::SEC_W'(1);
        end
        else
        begin
            usec_out_next = last_inc[ccti_pkg::USEC_W-1:0];
            sec_out_next  = last_sec_reg;
        end
    end

    // result goes out once the output register is free or being emptied
    assign out_load = (state_reg == ST_MONO) && (!m_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_cfg_reg  <= ccti_pkg::RATE_RESET;
            elapsed_reg   <= '0;
            sec_reg       <= '0;
            usec_reg      <= '0;
            sat_reg       <= 1'b0;
            last_sec_reg  <= '0;
            last_usec_reg <= '0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            m_user_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                rate_cfg_reg <= cfg_wdata;
            end

            // a new result refills the output register as the old one leaves
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        sec_reg     <= in_sec;
                        usec_reg    <= usec_clamped;
                        elapsed_reg <= in_cur_cyc - in_snap_cyc;
                        state_reg   <= ST_START;
                    end
                end
                ST_START:
                begin
                    // offset >= 1 s exactly when elapsed >= rate
                    sat_reg   <= (elapsed_reg >= rate);
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    sec_reg   <= sec_add_next;
                    usec_reg  <= usec_add_next;
                    state_reg <= ST_MONO;
                end
                ST_MONO:
                begin
                    if (out_load)
                    begin
                        last_sec_reg  <= sec_out_next;
                        last_usec_reg <= usec_out_next;
                        m_data_reg    <= {4'b0000, usec_out_next, sec_out_next};
                        m_user_reg    <= {bump_hit, sat_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef NO_ASSERTIONS
    // microseconds on the output never reach a full second
    a_usec_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[51:32] < ccti_pkg::USEC_PER_SEC))
        else $error("time_micros out of range");

    // same second as last time given must be strictly ahead of it
    a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (sec_out_next == last_sec_reg)) |-> (usec_out_next > last_usec_reg))
        else $error("result not ahead of last time");

    // a bumped word without a seconds carry holds exactly the last microseconds given plus one
    a_bump_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && bump_hit && !bump_carry) |=>
            (last_usec_reg == $past(last_usec_reg) + ccti_pkg::USEC_W'(1)))
        else $error("bump is not one microsecond");

    // units never signal done while the core is ready for a new word
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!mul_done && !div_done))
        else $error("arithmetic unit finished while idle");
`endif

endmodule

FILE: tb/tb_cycle_count_time_interpolator_core.sv
// Testbench for the cycle count time interpolator core: directed and random time reads.
`timescale 1ns / 1ps

module tb_cycle_count_time_interpolator_core;

    // Time to let the core settle after the last word before touching config.
    localparam int DRAIN_CYCLES = 70;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_READS = 235;    // per phase, 8 phases

    // Fields of one time read request, as packed on s_axis_tdata.
    typedef struct {
        logic [ccti_pkg::SEC_W-1:0]  sec;
        logic [ccti_pkg::USEC_W-1:0] usec;
        logic [ccti_pkg::CYC_W-1:0]  snap_cycles;
        logic [ccti_pkg::CYC_W-1:0]  cur_cycles;
    } time_read_t;

    // Fields of one returned time value.
    typedef struct {
        logic [ccti_pkg::SEC_W-1:0]  sec;
        logic [ccti_pkg::USEC_W-1:0] usec;
        logic                        saturated;
        logic                        bumped;
    } time_value_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [ccti_pkg::CYC_W-1:0]      cfg_wdata;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [ccti_pkg::S_DATA_W-1:0]   s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [ccti_pkg::M_DATA_W-1:0]   m_axis_tdata;
    logic [ccti_pkg::M_USER_W-1:0]   m_axis_tuser;

    // Shadow copy of the core's state: rate set by write_rate, last time kept by the time predictor.
    logic [ccti_pkg::CYC_W-1:0]      rate_q = ccti_pkg::RATE_RESET;
    logic [ccti_pkg::SEC_W-1:0]      last_sec_q = '0;
    logic [ccti_pkg::USEC_W-1:0]     last_usec_q = '0;

    time_value_t          expected_times[$];
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    int                   idle_pct = 0;     // sender gap chance per cycle, percent
    int                   stall_pct = 0;    // receiver stall chance per cycle, percent

    // Software-side view of the published snapshot used by the random reads.
    logic [ccti_pkg::SEC_W-1:0]      pub_sec;
    logic [ccti_pkg::USEC_W-1:0]     pub_usec;
    logic [ccti_pkg::CYC_W-1:0]      pub_cycles;

    cycle_count_time_interpolator_core i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cycle_count_time_interpolator_core test failed");
            $finish;
        end
    end

    // Predicts the core: elapsed cycles to microseconds, carry, then the
    // strict monotonic bump against the last time handed out.
    function automatic time_value_t interpolate_time(input time_read_t rd);
        time_value_t                 tv;
        logic [ccti_pkg::CYC_W-1:0]  rate;
        logic [ccti_pkg::CYC_W-1:0]  elapsed;
        logic [63:0]                 offset;
        logic [ccti_pkg::USEC_W:0]   usec;
        rate    = (rate_q == '0) ? ccti_pkg::CYC_W'(1) : rate_q;  // zero rate acts as 1 Hz
        elapsed = rd.cur_cycles - rd.snap_cycles;                 // one counter wrap allowed
        offset  = (64'(elapsed) * 64'(ccti_pkg::USEC_PER_SEC)) / 64'(rate);
        tv.saturated = (offset >= 64'(ccti_pkg::USEC_PER_SEC));
        if (tv.saturated)
            offset = 64'(ccti_pkg::USEC_MAX);
        usec = (rd.usec > ccti_pkg::USEC_MAX) ? {1'b0, ccti_pkg::USEC_MAX} : {1'b0, rd.usec};
        usec = usec + offset[ccti_pkg::USEC_W:0];
        tv.sec = rd.sec;
        if (usec >= {1'b0, ccti_pkg::USEC_PER_SEC})
        begin
            usec   = usec - {1'b0, ccti_pkg::USEC_PER_SEC};
            tv.sec = tv.sec + ccti_pkg::SEC_W'(1);
        end
        // earlier seconds are left alone, only the same second is bumped
        tv.bumped = (tv.sec == last_sec_q) && (usec <= {1'b0, last_usec_q});
        if (tv.bumped)
        begin
            usec = {1'b0, last_usec_q} + (ccti_pkg::USEC_W + 1)'(1);
            if (usec >= {1'b0, ccti_pkg::USEC_PER_SEC})
            begin
                usec   = usec - {1'b0, ccti_pkg::USEC_PER_SEC};
                tv.sec = tv.sec + ccti_pkg::SEC_W'(1);
            end
        end
        tv.usec     = usec[ccti_pkg::USEC_W-1:0];
        last_sec_q  = tv.sec;
        last_usec_q = tv.usec;
        return tv;
    endfunction

    function automatic time_read_t make_read(input logic [ccti_pkg::SEC_W-1:0] sec,
                                             input logic [ccti_pkg::USEC_W-1:0] usec,
                                             input logic [ccti_pkg::CYC_W-1:0] snap_cycles,
                                             input logic [ccti_pkg::CYC_W-1:0] cur_cycles);
        time_read_t rd;
        rd.sec         = sec;
        rd.usec        = usec;
        rd.snap_cycles = snap_cycles;
        rd.cur_cycles  = cur_cycles;
        return rd;
    endfunction

    // Sends one read word; the expectation is queued at the accepting edge.
    task automatic send_read(input time_read_t rd);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {4'b0, rd.cur_cycles, rd.snap_cycles, rd.usec, rd.sec};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_times.push_back(interpolate_time(rd));
    endtask

    // Drop valid, let every expected word come back, then let the core settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_times.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic [ccti_pkg::CYC_W-1:0] rate);
        wait_idle();
        cfg_wdata <= rate;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rate_q     = rate;
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
    endtask

    // Receiver: random stalls, and each accepted word checked against the oldest prediction.
    always @(posedge clk)
    begin
        time_value_t want;
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_times.size() == 0)
                flag_mismatch("unexpected word", '0, 64'(m_axis_tdata));
            else
            begin
                want = expected_times.pop_front();
                if (m_axis_tdata[ccti_pkg::SEC_W-1:0] !== want.sec)
                    flag_mismatch("time_seconds", 64'(want.sec),
                                  64'(m_axis_tdata[ccti_pkg::SEC_W-1:0]));
                if (m_axis_tdata[ccti_pkg::SEC_W +: ccti_pkg::USEC_W] !== want.usec)
                    flag_mismatch("time_micros", 64'(want.usec),
                                  64'(m_axis_tdata[ccti_pkg::SEC_W +: ccti_pkg::USEC_W]));
                if (m_axis_tuser[0] !== want.saturated)
                    flag_mismatch("offset_saturated", 64'(want.saturated),
                                  64'(m_axis_tuser[0]));
                if (m_axis_tuser[1] !== want.bumped)
                    flag_mismatch("bumped", 64'(want.bumped), 64'(m_axis_tuser[1]));
            end
        end
    end

    // Corner cases at the reset rate of 100 MHz, one word in flight at a time.
    task automatic test_corner_reads();
        send_read(make_read(32'd0, 20'd0, 32'd0, 32'd0));              // bump from reset state
        wait_idle();
        send_read(make_read(32'd0, 20'd1, 32'd0, 32'd0));              // equal micros, bump
        wait_idle();
        send_read(make_read(32'd10, 20'd999999, 32'd100, 32'd200));    // micro carry
        wait_idle();
        send_read(make_read(32'd20, 20'd0, 32'hFFFF_FF00, 32'h0000_0100)); // counter wrap
        wait_idle();
        send_read(make_read(32'd30, 20'd0, 32'd0, 32'd100000000));     // exactly one second
        wait_idle();
        send_read(make_read(32'd30, 20'd5, 32'd0, 32'hFFFF_FFFF));     // largest elapsed
        send_read(make_read(32'd40, 20'hFFFFF, 32'd7, 32'd7));         // micros clamp
        send_read(make_read(32'd40, 20'd500000, 32'd0, 32'd0));        // bump with carry
        send_read(make_read(32'd5, 20'd0, 32'd0, 32'd0));              // earlier second kept
        send_read(make_read(32'hFFFF_FFFF, 20'd999999, 32'd0, 32'd100)); // seconds wrap
        send_read(make_read(32'd0, 20'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));  // bump at zero
        send_read(make_read(32'd0, 20'd999998, 32'hFFFF_FFFF, 32'h0000_0063)); // counter wrap, no carry
        wait_idle();
    endtask

    // Rate register extremes: zero acts as one, one, and the full 32-bit rate.
    task automatic test_rate_extremes();
        write_rate('0);
        send_read(make_read(32'd100, 20'd0, 32'd10, 32'd10));
        send_read(make_read(32'd101, 20'd0, 32'd10, 32'd11));
        write_rate(ccti_pkg::CYC_W'(1));
        send_read(make_read(32'd102, 20'd3, 32'd0, 32'd0));
        send_read(make_read(32'd102, 20'd3, 32'd0, 32'd1));
        write_rate('1);
        send_read(make_read(32'd103, 20'd0, 32'd0, 32'hFFFF_FFFF));   // exactly one second
        send_read(make_read(32'd104, 20'd0, 32'd0, 32'hFFFF_FFFE));   // just under
        send_read(make_read(32'd105, 20'd0, 32'd1, 32'h0000_1000));
        wait_idle();
    endtask

    // Mostly reads against a published snapshot, as software would issue them,
    // with the rest fully random words.
    task automatic test_random_reads(input int count);
        time_read_t                  rd;
        logic [ccti_pkg::CYC_W-1:0]  span;
        logic [ccti_pkg::CYC_W-1:0]  elapsed;
        int                          pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                rd = make_read($urandom, ccti_pkg::USEC_W'($urandom), $urandom, $urandom);
            else
            begin
                if (pick < 30)
                begin
                    // new snapshot: same or next second, fresh micros and count
                    pub_sec    = pub_sec + $urandom_range(0, 1);
                    pub_usec   = ccti_pkg::USEC_W'($urandom_range(0, 999999));
                    pub_cycles = pub_cycles + $urandom;
                end
                span = (rate_q == '0) ? '0 : rate_q - ccti_pkg::CYC_W'(1);
                if (pick < 38)
                    elapsed = span + $urandom_range(0, 3);  // at the saturation edge
                else if (pick < 44)
                    elapsed = $urandom;
                else
                    elapsed = $urandom_range(0, span);
                rd = make_read(pub_sec, pub_usec, pub_cycles, pub_cycles + elapsed);
            end
            send_read(rd);
        end
    endtask

    // Eight phases: each idling mode twice, each with its own clock rate.
    task automatic test_random_phases();
        logic [ccti_pkg::CYC_W-1:0] rates[8];
        rates[0] = ccti_pkg::RATE_RESET;
        rates[1] = 32'd1000000;
        rates[2] = 32'd1;
        rates[3] = $urandom_range(2, 5000);
        rates[4] = '1;
        rates[5] = 32'd32768;
        rates[6] = $urandom;
        rates[7] = 32'd25000000;
        pub_sec    = $urandom;
        pub_usec   = ccti_pkg::USEC_W'($urandom_range(0, 999999));
        pub_cycles = $urandom;
        for (int p = 0; p < 8; p++)
        begin
            write_rate(rates[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            test_random_reads(RANDOM_READS);
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_reads();
        test_rate_extremes();
        test_random_phases();

        wait_idle();
        if (mismatch_count == 0)
            $display("cycle_count_time_interpolator_core test passed");
        else
            $display("cycle_count_time_interpolator_core test failed");
        $finish;
    end

endmodule

FILE: sim.f
design/ccti_pkg.sv
design/ccti_mul.sv
design/ccti_div.sv
design/cycle_count_time_interpolator_core.sv
tb/tb_cycle_count_time_interpolator_core.sv
